// ===== rtl/scgs_pkg.sv =====
`default_nettype none

package scgs_pkg;

    // Default sizes
    localparam int MAX_UNKNOWNS_DEF = 128;
    localparam int ROW_SLOTS_DEF    = 7;

    // Field widths
    localparam int REQ_W   = 3;
    localparam int IDX_W   = 7;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 8;
    localparam int CFGI_W  = 1;
    localparam int ACC_W   = 64;
    localparam int DCNT_W  = 6;

    // Register reset values
    localparam logic [CFG_W-1:0] CFG_N_RST  = 8'd128;
    localparam logic [CFG_W-1:0] CFG_IT_RST = 8'd20;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_ACTIVE = 1'b0;
    localparam logic [CFGI_W-1:0] CFG_MAXIT  = 1'b1;

    // Request types
    localparam logic [REQ_W-1:0] REQ_ASSIGN  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SETDIAG = 3'd1;
    localparam logic [REQ_W-1:0] REQ_LOAD    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SOLVE   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_ROWFULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERODIV = 2'd2;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            res = Q_MAX;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            res = Q_MIN;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sparse_conjugate_gradient_solver.sv =====
// Sparse conjugate-gradient solver in signed Q16.16. Requests: assign entry, set diagonal,
// load rhs, solve, read solution; each gives one response echoing row_index. Assign and
// set-diagonal scan the row's stored slots, reading then comparing each slot in turn.
// Solve runs on one shared 32x32 multiplier and a radix-2 divider. Input stall is high
// from acceptance until the response is placed in the output register.
`default_nettype none

module sparse_conjugate_gradient_solver #(
    parameter int MAX_UNKNOWNS = scgs_pkg::MAX_UNKNOWNS_DEF,
    parameter int ROW_SLOTS    = scgs_pkg::ROW_SLOTS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // request channel
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire  [scgs_pkg::REQ_W-1:0]       i_req_type,
    input  wire  [scgs_pkg::IDX_W-1:0]       i_row_index,
    input  wire  [scgs_pkg::IDX_W-1:0]       i_column_index,
    input  wire  signed [scgs_pkg::DATA_W-1:0] i_data_value,
    // response channel
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [scgs_pkg::IDX_W-1:0]       o_result_index,
    output logic signed [scgs_pkg::DATA_W-1:0] o_result_value,
    output logic [scgs_pkg::STAT_W-1:0]      o_status,
    // configuration channel
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [scgs_pkg::CFGI_W-1:0]      i_cfg_index,
    input  wire  [scgs_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int AW     = $clog2(MAX_UNKNOWNS);
    localparam int NW     = $clog2(MAX_UNKNOWNS + 1);
    localparam int SW     = $clog2(ROW_SLOTS + 1);
    localparam int EDEPTH = MAX_UNKNOWNS * ROW_SLOTS;
    localparam int EAW    = $clog2(EDEPTH);
    localparam int DW     = scgs_pkg::DATA_W;
    localparam int XW     = scgs_pkg::ACC_W;
    localparam int IW     = scgs_pkg::IDX_W;

    typedef enum logic [20:0] {
        S_IDLE   = 21'h000001,
        S_RDX    = 21'h000002,
        S_FILL   = 21'h000004,
        S_SCAN   = 21'h000008,
        S_SCMP   = 21'h000010,
        S_ENTW   = 21'h000020,
        S_DONE   = 21'h000040,
        S_VRD    = 21'h000080,
        S_VM1    = 21'h000100,
        S_VM2    = 21'h000200,
        S_VWB    = 21'h000400,
        S_MFILL  = 21'h000800,
        S_MFWAIT = 21'h001000,
        S_MERD   = 21'h002000,
        S_MEDAT  = 21'h004000,
        S_MMUL   = 21'h008000,
        S_MACC   = 21'h010000,
        S_MWB    = 21'h020000,
        S_DCHK   = 21'h040000,
        S_DIT    = 21'h080000,
        S_DFIN   = 21'h100000
    } t_state;

    typedef enum logic [4:0] {
        P_INIT = 5'b00001,
        P_DEN  = 5'b00010,
        P_UPD  = 5'b00100,
        P_RDOT = 5'b01000,
        P_DIR  = 5'b10000
    } t_pass;

    // control
    t_state                        r_state;
    t_pass                         r_pass;
    logic                          r_o_vld;
    logic [scgs_pkg::CFG_W-1:0]    r_cfg_n;
    logic [scgs_pkg::CFG_W-1:0]    r_cfg_it;
    logic [MAX_UNKNOWNS-1:0]       r_fill_vld;
    logic [MAX_UNKNOWNS-1:0]       r_x_vld;

    // request and response payload
    logic [scgs_pkg::REQ_W-1:0]    r_req;
    logic [IW-1:0]                 r_row;
    logic [IW-1:0]                 r_col;
    logic signed [DW-1:0]          r_data;
    logic signed [DW-1:0]          r_val;
    logic [scgs_pkg::STAT_W-1:0]   r_status;
    logic [IW-1:0]                 r_o_idx;
    logic signed [DW-1:0]          r_o_val;
    logic [scgs_pkg::STAT_W-1:0]   r_o_st;

    // row scan
    logic [SW-1:0]                 r_fill;
    logic [SW-1:0]                 r_j;
    logic [SW-1:0]                 r_pos;
    logic                          r_found;
    logic signed [XW-1:0]          r_sum;
    logic                          r_ok;

    // solve datapath
    logic [NW-1:0]                 r_i;
    logic [scgs_pkg::CFG_W-1:0]    r_k;
    logic signed [XW-1:0]          r_acc;
    logic signed [XW-1:0]          r_prod;
    logic signed [XW-1:0]          r_prod_a;
    logic signed [XW-1:0]          r_rdot;
    logic signed [XW-1:0]          r_next;
    logic signed [DW-1:0]          r_alpha;
    logic signed [DW-1:0]          r_beta;
    logic                          r_zero;

    // divider
    logic signed [XW-1:0]          r_dnum;
    logic signed [XW-1:0]          r_dden;
    logic                          r_dsel_beta;
    logic [XW-1:0]                 r_ud;
    logic [XW-1:0]                 r_rem;
    logic [DW-1:0]                 r_dsh;
    logic [DW-1:0]                 r_q;
    logic                          r_ovf;
    logic                          r_neg;
    logic                          r_dzero;
    logic [scgs_pkg::DCNT_W-1:0]   r_cnt;

    // memories
    logic [SW-1:0]                 r_fill_mem [MAX_UNKNOWNS];
    logic [IW-1:0]                 r_col_mem  [EDEPTH];
    logic signed [DW-1:0]          r_eval_mem [EDEPTH];
    logic signed [DW-1:0]          r_rhs_mem  [MAX_UNKNOWNS];
    logic signed [DW-1:0]          r_x_mem    [MAX_UNKNOWNS];
    logic signed [DW-1:0]          r_r_mem    [MAX_UNKNOWNS];
    logic signed [DW-1:0]          r_p_mem    [MAX_UNKNOWNS];
    logic signed [DW-1:0]          r_ap_mem   [MAX_UNKNOWNS];

    logic [SW-1:0]                 r_fill_q;
    logic [IW-1:0]                 r_col_q;
    logic signed [DW-1:0]          r_eval_q;
    logic signed [DW-1:0]          r_rhs_q;
    logic signed [DW-1:0]          r_x_q;
    logic signed [DW-1:0]          r_r_q;
    logic signed [DW-1:0]          r_p_q;
    logic signed [DW-1:0]          r_ap_q;

    logic                          w_acc_in;
    logic [NW-1:0]                 w_n;
    logic                          w_in_row_ok;
    logic                          w_last;
    logic [AW-1:0]                 w_row_a;
    logic [AW-1:0]                 w_i_a;
    logic [SW-1:0]                 w_fill_eff;
    logic signed [XW-1:0]          w_abs_data;

    logic                          w_fill_re;
    logic [AW-1:0]                 w_fill_ra;
    logic                          w_fill_we;
    logic                          w_ent_re;
    logic [EAW-1:0]                w_ent_ra;
    logic                          w_eval_we;
    logic                          w_col_we;
    logic [EAW-1:0]                w_ent_wa;
    logic signed [DW-1:0]          w_eval_wd;
    logic [IW-1:0]                 w_col_wd;
    logic                          w_rhs_we;
    logic                          w_x_re;
    logic [AW-1:0]                 w_x_ra;
    logic                          w_x_we;
    logic signed [DW-1:0]          w_x_wd;
    logic                          w_r_we;
    logic signed [DW-1:0]          w_r_wd;
    logic                          w_p_re;
    logic [AW-1:0]                 w_p_ra;
    logic                          w_p_we;
    logic signed [DW-1:0]          w_p_wd;
    logic                          w_v_re;

    logic signed [DW-1:0]          w_ma;
    logic signed [DW-1:0]          w_mb;
    logic signed [XW-1:0]          w_full;

    logic [XW-1:0]                 w_un;
    logic [XW-1:0]                 w_udn;
    logic                          w_ovf;
    logic [XW:0]                   w_t;
    logic                          w_ge;
    logic [DW:0]                   w_q33;
    logic signed [DW-1:0]          w_dres;

    assign w_acc_in    = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid        = r_o_vld;
    assign o_result_index = r_o_idx;
    assign o_result_value = r_o_val;
    assign o_status       = r_o_st;

    // Effective unknown count: zero acts as one, clamp to capacity
    always_comb begin
        if (r_cfg_n == '0) begin
            w_n = NW'(1);
        end else if (32'(r_cfg_n) > 32'(MAX_UNKNOWNS)) begin
            w_n = NW'(MAX_UNKNOWNS);
        end else begin
            w_n = NW'(r_cfg_n);
        end
    end

    assign w_in_row_ok = 32'(i_row_index) < 32'(w_n);
    assign w_last      = (32'(r_i) + 32'd1) >= 32'(w_n);
    assign w_row_a     = AW'(r_row);
    assign w_i_a       = r_i[AW-1:0];
    assign w_abs_data  = r_data[DW-1] ? -XW'(r_data) : XW'(r_data);

    // Stored fill of the row in hand, never-written rows read as empty
    always_comb begin
        logic vld;
        vld = (r_state == S_FILL) ? r_fill_vld[w_row_a] : r_fill_vld[w_i_a];
        if (!vld) begin
            w_fill_eff = '0;
        end else if (32'(r_fill_q) > 32'(ROW_SLOTS)) begin
            w_fill_eff = SW'(ROW_SLOTS);
        end else begin
            w_fill_eff = r_fill_q;
        end
    end

    // Memory port control
    always_comb begin
        w_fill_re = 1'b0;
        w_fill_ra = w_i_a;
        w_fill_we = 1'b0;
        w_ent_re  = 1'b0;
        w_ent_ra  = EAW'(32'(w_i_a) * 32'(ROW_SLOTS) + 32'(r_j));
        w_eval_we = 1'b0;
        w_col_we  = 1'b0;
        w_ent_wa  = EAW'(32'(w_row_a) * 32'(ROW_SLOTS) + 32'(r_found ? r_pos : r_fill));
        w_eval_wd = (r_req == scgs_pkg::REQ_ASSIGN) ? r_data : scgs_pkg::sat32(r_sum);
        w_col_wd  = (r_req == scgs_pkg::REQ_ASSIGN) ? r_col : r_row;
        w_rhs_we  = w_acc_in && (i_req_type == scgs_pkg::REQ_LOAD) && w_in_row_ok;
        w_x_re    = 1'b0;
        w_x_ra    = w_i_a;
        w_x_we    = 1'b0;
        w_x_wd    = '0;
        w_r_we    = 1'b0;
        w_r_wd    = r_rhs_q;
        w_p_re    = 1'b0;
        w_p_ra    = w_i_a;
        w_p_we    = 1'b0;
        w_p_wd    = r_rhs_q;
        w_v_re    = (r_state == S_VRD);
        if (w_acc_in && (i_req_type == scgs_pkg::REQ_READ)) begin
            w_x_re = 1'b1;
            w_x_ra = AW'(i_row_index);
        end
        if (w_acc_in && (i_req_type == scgs_pkg::REQ_ASSIGN || i_req_type == scgs_pkg::REQ_SETDIAG)) begin
            w_fill_re = 1'b1;
            w_fill_ra = AW'(i_row_index);
        end
        if (r_state == S_MFILL) begin
            w_fill_re = 1'b1;
        end
        if (r_state == S_SCAN) begin
            w_ent_re = 1'b1;
            w_ent_ra = EAW'(32'(w_row_a) * 32'(ROW_SLOTS) + 32'(r_j));
        end
        if (r_state == S_MERD) begin
            w_ent_re = 1'b1;
        end
        if (r_state == S_ENTW) begin
            w_eval_we = r_found || (32'(r_fill) < 32'(ROW_SLOTS));
            w_col_we  = !r_found && (32'(r_fill) < 32'(ROW_SLOTS));
            w_fill_we = w_col_we;
        end
        if (r_state == S_VRD) begin
            w_x_re = 1'b1;
            w_p_re = 1'b1;
        end
        if (r_state == S_MEDAT) begin
            w_p_re = 1'b1;
            w_p_ra = AW'(r_col_q);
        end
        if (r_state == S_VWB) begin
            case (r_pass)
                P_INIT: begin
                    w_x_we = 1'b1;
                    w_r_we = 1'b1;
                    w_p_we = 1'b1;
                end
                P_UPD: begin
                    w_x_we = 1'b1;
                    w_x_wd = scgs_pkg::sat32(XW'(r_x_q) + r_prod_a);
                    w_r_we = 1'b1;
                    w_r_wd = scgs_pkg::sat32(XW'(r_r_q) - r_prod);
                end
                P_DIR: begin
                    w_p_we = 1'b1;
                    w_p_wd = scgs_pkg::sat32(XW'(r_r_q) + r_prod_a);
                end
                default: begin
                end
            endcase
        end
    end

    // Row fill counts
    always_ff @(posedge i_clk) begin
        if (w_fill_we) begin
            r_fill_mem[w_row_a] <= r_fill + SW'(1);
        end
        if (w_fill_re) begin
            r_fill_q <= r_fill_mem[w_fill_ra];
        end
    end

    // Entry columns and values
    always_ff @(posedge i_clk) begin
        if (w_col_we) begin
            r_col_mem[w_ent_wa] <= w_col_wd;
        end
        if (w_eval_we) begin
            r_eval_mem[w_ent_wa] <= w_eval_wd;
        end
        if (w_ent_re) begin
            r_col_q  <= r_col_mem[w_ent_ra];
            r_eval_q <= r_eval_mem[w_ent_ra];
        end
    end

    // Right-hand side
    always_ff @(posedge i_clk) begin
        if (w_rhs_we) begin
            r_rhs_mem[AW'(i_row_index)] <= i_data_value;
        end
        if (w_v_re) begin
            r_rhs_q <= r_rhs_mem[w_i_a];
        end
    end

    // Solution
    always_ff @(posedge i_clk) begin
        if (w_x_we) begin
            r_x_mem[w_i_a] <= w_x_wd;
        end
        if (w_x_re) begin
            r_x_q <= r_x_mem[w_x_ra];
        end
    end

    // Residual
    always_ff @(posedge i_clk) begin
        if (w_r_we) begin
            r_r_mem[w_i_a] <= w_r_wd;
        end
        if (w_v_re) begin
            r_r_q <= r_r_mem[w_i_a];
        end
    end

    // Search direction
    always_ff @(posedge i_clk) begin
        if (w_p_we) begin
            r_p_mem[w_i_a] <= w_p_wd;
        end
        if (w_p_re) begin
            r_p_q <= r_p_mem[w_p_ra];
        end
    end

    // Matrix times direction
    always_ff @(posedge i_clk) begin
        if (r_state == S_MWB) begin
            r_ap_mem[w_i_a] <= scgs_pkg::sat32(r_acc);
        end
        if (w_v_re) begin
            r_ap_q <= r_ap_mem[w_i_a];
        end
    end

    // Shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == S_VM1) begin
            case (r_pass)
                P_INIT: begin
                    w_ma = r_rhs_q;
                    w_mb = r_rhs_q;
                end
                P_DEN: begin
                    w_ma = r_p_q;
                    w_mb = r_ap_q;
                end
                P_UPD: begin
                    w_ma = r_alpha;
                    w_mb = r_p_q;
                end
                P_RDOT: begin
                    w_ma = r_r_q;
                    w_mb = r_r_q;
                end
                default: begin
                    w_ma = r_beta;
                    w_mb = r_p_q;
                end
            endcase
        end else if (r_state == S_VM2) begin
            w_ma = r_alpha;
            w_mb = r_ap_q;
        end else if (r_state == S_MMUL) begin
            w_ma = r_eval_q;
            w_mb = r_p_q;
        end
    end

    assign w_full = w_ma * w_mb;

    // Divider front end and step
    assign w_un  = r_dnum[XW-1] ? XW'(-r_dnum) : XW'(r_dnum);
    assign w_udn = r_dden[XW-1] ? XW'(-r_dden) : XW'(r_dden);
    assign w_ovf = {16'd0, w_un} >= {w_udn, 16'd0};
    assign w_t   = {r_rem, r_dsh[DW-1]};
    assign w_ge  = w_t >= {1'b0, r_ud};
    assign w_q33 = r_ovf ? {1'b1, 32'd0} : {1'b0, r_q};

    always_comb begin
        if (r_dzero) begin
            if (r_dnum > 0) begin
                w_dres = scgs_pkg::Q_MAX;
            end else if (r_dnum < 0) begin
                w_dres = scgs_pkg::Q_MIN;
            end else begin
                w_dres = '0;
            end
        end else if (!r_neg) begin
            w_dres = (w_q33 > 33'h0_7FFF_FFFF) ? scgs_pkg::Q_MAX : signed'(w_q33[DW-1:0]);
        end else begin
            w_dres = (w_q33 >= 33'h0_8000_0000) ? scgs_pkg::Q_MIN
                                                : signed'(-w_q33[DW-1:0]);
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pass     <= P_INIT;
            r_o_vld    <= 1'b0;
            r_cfg_n    <= scgs_pkg::CFG_N_RST;
            r_cfg_it   <= scgs_pkg::CFG_IT_RST;
            r_fill_vld <= '0;
            r_x_vld    <= '0;
        end else begin
            // configuration writes
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    scgs_pkg::CFG_ACTIVE: r_cfg_n  <= i_cfg_data;
                    scgs_pkg::CFG_MAXIT:  r_cfg_it <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // drop response once taken, unless a new one replaces it
            if (r_o_vld && !i_stall && (r_state != S_DONE)) begin
                r_o_vld <= 1'b0;
            end

            if (w_fill_we) begin
                r_fill_vld[w_row_a] <= 1'b1;
            end
            if (w_x_we) begin
                r_x_vld[w_i_a] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        r_req    <= i_req_type;
                        r_row    <= i_row_index;
                        r_col    <= i_column_index;
                        r_data   <= i_data_value;
                        r_val    <= '0;
                        r_status <= scgs_pkg::ST_OK;
                        unique case (i_req_type) inside
                            scgs_pkg::REQ_ASSIGN, scgs_pkg::REQ_SETDIAG: begin
                                r_state <= w_in_row_ok ? S_FILL : S_DONE;
                            end
                            scgs_pkg::REQ_SOLVE: begin
                                r_pass  <= P_INIT;
                                r_i     <= '0;
                                r_acc   <= '0;
                                r_zero  <= 1'b0;
                                r_state <= S_VRD;
                            end
                            scgs_pkg::REQ_READ: begin
                                r_state <= w_in_row_ok ? S_RDX : S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end

                S_RDX: begin
                    r_val   <= r_x_vld[w_row_a] ? r_x_q : '0;
                    r_state <= S_DONE;
                end

                S_FILL: begin
                    r_fill  <= w_fill_eff;
                    r_j     <= '0;
                    r_pos   <= '0;
                    r_found <= 1'b0;
                    r_sum   <= w_abs_data;
                    r_state <= S_SCAN;
                end

                S_SCAN: begin
                    r_state <= (r_j < r_fill) ? S_SCMP : S_ENTW;
                end

                // assign stops at the matching slot; set-diagonal subtracts every other slot's value
                S_SCMP: begin
                    if (r_req == scgs_pkg::REQ_ASSIGN) begin
                        if (r_col_q == r_col) begin
                            r_found <= 1'b1;
                            r_pos   <= r_j;
                            r_state <= S_ENTW;
                        end else begin
                            r_j     <= r_j + SW'(1);
                            r_state <= S_SCAN;
                        end
                    end else begin
                        if (r_col_q == r_row) begin
                            r_found <= 1'b1;
                            r_pos   <= r_j;
                        end else begin
                            r_sum <= r_sum - XW'(r_eval_q);
                        end
                        r_j     <= r_j + SW'(1);
                        r_state <= S_SCAN;
                    end
                end

                S_ENTW: begin
                    if (!r_found && !(32'(r_fill) < 32'(ROW_SLOTS))) begin
                        r_status <= scgs_pkg::ST_ROWFULL;
                    end
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    if (!r_o_vld || !i_stall) begin
                        r_o_vld <= 1'b1;
                        r_o_idx <= r_row;
                        r_o_val <= r_val;
                        r_o_st  <= r_status;
                        r_state <= S_IDLE;
                    end
                end

                // element pass: read, first product, second product, write back
                S_VRD: begin
                    r_state <= S_VM1;
                end

                S_VM1: begin
                    r_prod  <= w_full >>> 16;
                    r_state <= S_VM2;
                end

                S_VM2: begin
                    r_prod_a <= r_prod;
                    r_prod   <= w_full >>> 16;
                    r_state  <= S_VWB;
                end

                S_VWB: begin
                    if (r_pass == P_INIT || r_pass == P_DEN || r_pass == P_RDOT) begin
                        r_acc <= r_acc + r_prod_a;
                    end
                    if (!w_last) begin
                        r_i     <= r_i + NW'(1);
                        r_state <= S_VRD;
                    end else begin
                        r_i <= '0;
                        case (r_pass)
                            P_INIT: begin
                                r_rdot  <= r_acc + r_prod_a;
                                r_k     <= '0;
                                r_state <= S_MFILL;
                            end
                            P_DEN: begin
                                r_dnum      <= r_rdot;
                                r_dden      <= r_acc + r_prod_a;
                                r_dsel_beta <= 1'b0;
                                r_state     <= S_DCHK;
                            end
                            P_UPD: begin
                                if (r_k >= r_cfg_it) begin
                                    r_status <= r_zero ? scgs_pkg::ST_ZERODIV : scgs_pkg::ST_OK;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_pass  <= P_RDOT;
                                    r_acc   <= '0;
                                    r_state <= S_VRD;
                                end
                            end
                            P_RDOT: begin
                                r_next      <= r_acc + r_prod_a;
                                r_dnum      <= r_acc + r_prod_a;
                                r_dden      <= r_rdot;
                                r_dsel_beta <= 1'b1;
                                r_state     <= S_DCHK;
                            end
                            default: begin
                                r_rdot  <= r_next;
                                r_k     <= r_k + 8'd1;
                                r_state <= S_MFILL;
                            end
                        endcase
                    end
                end

                // sparse row times direction
                S_MFILL: begin
                    r_state <= S_MFWAIT;
                end

                S_MFWAIT: begin
                    r_fill  <= w_fill_eff;
                    r_j     <= '0;
                    r_acc   <= '0;
                    r_state <= S_MERD;
                end

                S_MERD: begin
                    r_state <= (r_j < r_fill) ? S_MEDAT : S_MWB;
                end

                S_MEDAT: begin
                    r_ok    <= 32'(r_col_q) < 32'(w_n);
                    r_state <= S_MMUL;
                end

                S_MMUL: begin
                    r_prod  <= w_full >>> 16;
                    r_state <= S_MACC;
                end

                S_MACC: begin
                    if (r_ok) begin
                        r_acc <= r_acc + r_prod;
                    end
                    r_j     <= r_j + SW'(1);
                    r_state <= S_MERD;
                end

                S_MWB: begin
                    if (!w_last) begin
                        r_i     <= r_i + NW'(1);
                        r_state <= S_MFILL;
                    end else begin
                        r_i     <= '0;
                        r_acc   <= '0;
                        r_pass  <= P_DEN;
                        r_state <= S_VRD;
                    end
                end

                // quotient num*2^16/den, one bit a cycle
                S_DCHK: begin
                    r_ud    <= w_udn;
                    r_rem   <= {16'd0, w_un[XW-1:16]};
                    r_dsh   <= {w_un[15:0], 16'd0};
                    r_q     <= '0;
                    r_ovf   <= w_ovf;
                    r_neg   <= r_dnum[XW-1] ^ r_dden[XW-1];
                    r_dzero <= (r_dden == '0);
                    r_cnt   <= '0;
                    r_state <= ((r_dden == '0) || w_ovf) ? S_DFIN : S_DIT;
                end

                S_DIT: begin
                    r_rem   <= w_ge ? XW'(w_t - {1'b0, r_ud}) : w_t[XW-1:0];
                    r_q     <= {r_q[DW-2:0], w_ge};
                    r_dsh   <= {r_dsh[DW-2:0], 1'b0};
                    r_cnt   <= r_cnt + 6'd1;
                    r_state <= (r_cnt == 6'd31) ? S_DFIN : S_DIT;
                end

                S_DFIN: begin
                    if (r_dzero) begin
                        r_zero <= 1'b1;
                    end
                    if (r_dsel_beta) begin
                        r_beta <= w_dres;
                        r_pass <= P_DIR;
                    end else begin
                        r_alpha <= w_dres;
                        r_pass  <= P_UPD;
                    end
                    r_i     <= '0;
                    r_state <= S_VRD;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // an accepted request always leaves idle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_in |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // divider step count never runs past the quotient width
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIT) |-> (r_cnt < 6'd32))
        else $error("divider iterated past 32 steps");

    // row-full status only comes from entry writes
    a_rowfull_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == scgs_pkg::ST_ROWFULL) |->
        (r_req == scgs_pkg::REQ_ASSIGN || r_req == scgs_pkg::REQ_SETDIAG))
        else $error("row-full status on a request that writes no entry");

    // slot walk stays inside the row fill
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERD || r_state == S_SCAN) |-> (r_j <= r_fill))
        else $error("slot index beyond row fill");

endmodule

`default_nettype wire

// ===== tb/sparse_conjugate_gradient_solver_test.sv =====
module sparse_conjugate_gradient_solver_test;
    import scgs_pkg::*;

    localparam int NMAX        = MAX_UNKNOWNS_DEF;
    localparam int SLOTS       = ROW_SLOTS_DEF;
    localparam int IDLE_LIMIT  = 200000;
    localparam int LONG_HOLD   = 400;
    localparam logic [REQ_W-1:0] REQ_TOP = {REQ_W{1'b1}};

    typedef struct {
        logic [REQ_W-1:0]         req;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] data;
    } request_t;

    typedef struct {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] value;
        logic [STAT_W-1:0]        status;
    } response_t;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [REQ_W-1:0]            i_req_type = '0;
    logic [IDX_W-1:0]            i_row_index = '0;
    logic [IDX_W-1:0]            i_column_index = '0;
    logic signed [DATA_W-1:0]    i_data_value = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic [IDX_W-1:0]            o_result_index;
    logic signed [DATA_W-1:0]    o_result_value;
    logic [STAT_W-1:0]           o_status;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFGI_W-1:0]           i_cfg_index = '0;
    logic [CFG_W-1:0]            i_cfg_data = '0;

    sparse_conjugate_gradient_solver uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_row_index(i_row_index),
        .i_column_index(i_column_index), .i_data_value(i_data_value),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result_index(o_result_index), .o_result_value(o_result_value),
        .o_status(o_status),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    request_t  pending_requests[$];
    response_t expected_responses[$];
    int        fails = 0;
    bit        quiet = 1'b0;
    int        long_hold_req = 0;

    // Predicted block state
    logic [CFG_W-1:0]         mdl_active;
    logic [CFG_W-1:0]         mdl_maxit;
    int                       mdl_fill[NMAX];
    logic [IDX_W-1:0]         mdl_col[NMAX][SLOTS];
    logic signed [DATA_W-1:0] mdl_val[NMAX][SLOTS];
    logic signed [DATA_W-1:0] mdl_rhs[NMAX];
    logic signed [DATA_W-1:0] mdl_x[NMAX];
    logic signed [DATA_W-1:0] mdl_r[NMAX];
    logic signed [DATA_W-1:0] mdl_p[NMAX];
    logic signed [DATA_W-1:0] mdl_ap[NMAX];
    longint                   mdl_rdot;
    bit                       div_zero;

    function automatic int eff_unknowns(logic [CFG_W-1:0] a);
        int n;
        n = a;
        if (n == 0) n = 1;
        if (n > NMAX) n = NMAX;
        return n;
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp32(longint v);
        if (v > 64'sh7FFF_FFFF) return Q_MAX;
        if (v < -64'sh8000_0000) return Q_MIN;
        return v[DATA_W-1:0];
    endfunction

    // Q16.16 product, floor rounding
    function automatic longint fx_mul(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> 16;
    endfunction

    // num*2^16/den truncated toward zero, saturated; flags a zero divisor
    function automatic logic signed [DATA_W-1:0] fx_div(longint num, longint den);
        longint unsigned un, ud, ip, rem, q;
        bit neg;
        if (den == 0) begin
            div_zero = 1'b1;
            if (num > 0) return Q_MAX;
            if (num < 0) return Q_MIN;
            return '0;
        end
        un = num < 0 ? longint'(-num) : num;
        ud = den < 0 ? longint'(-den) : den;
        neg = (num < 0) != (den < 0);
        ip = un / ud;
        rem = un % ud;
        if (ip >= 65536) begin
            q = 64'd1 << 32;
        end else begin
            q = ip << 16;
            for (int i = 15; i >= 0; i--) begin
                rem = rem << 1;
                if (rem >= ud) begin
                    rem = rem - ud;
                    q = q | (64'd1 << i);
                end
            end
        end
        if (!neg) return (q > 64'h7FFF_FFFF) ? Q_MAX : q[DATA_W-1:0];
        if (q >= 64'h8000_0000) return Q_MIN;
        return -q[DATA_W-1:0];
    endfunction

    function automatic longint dot_rr(int n);
        longint acc;
        acc = 0;
        for (int i = 0; i < n; i++) acc += fx_mul(mdl_r[i], mdl_r[i]);
        return acc;
    endfunction

    // Conjugate gradient from x = 0
    function automatic void cg_solve(int n);
        longint den, nxt;
        logic signed [DATA_W-1:0] alpha, beta;
        longint acc;
        for (int i = 0; i < n; i++) begin
            mdl_x[i] = '0;
            mdl_r[i] = mdl_rhs[i];
            mdl_p[i] = mdl_rhs[i];
        end
        mdl_rdot = dot_rr(n);
        for (int k = 0; ; k++) begin
            for (int i = 0; i < n; i++) begin
                acc = 0;
                for (int j = 0; j < mdl_fill[i]; j++)
                    if (mdl_col[i][j] < n) acc += fx_mul(mdl_val[i][j], mdl_p[mdl_col[i][j]]);
                mdl_ap[i] = clamp32(acc);
            end
            den = 0;
            for (int i = 0; i < n; i++) den += fx_mul(mdl_p[i], mdl_ap[i]);
            alpha = fx_div(mdl_rdot, den);
            for (int i = 0; i < n; i++) begin
                mdl_x[i] = clamp32(longint'(mdl_x[i]) + fx_mul(alpha, mdl_p[i]));
                mdl_r[i] = clamp32(longint'(mdl_r[i]) - fx_mul(alpha, mdl_ap[i]));
            end
            if (k >= mdl_maxit) break;
            nxt = dot_rr(n);
            beta = fx_div(nxt, mdl_rdot);
            for (int i = 0; i < n; i++)
                mdl_p[i] = clamp32(longint'(mdl_r[i]) + fx_mul(beta, mdl_p[i]));
            mdl_rdot = nxt;
        end
    endfunction

    // Apply one accepted request to the predicted state
    function automatic response_t apply_request(request_t rq);
        response_t rs;
        int n, fill, pos;
        bit found;
        longint sum;
        n = eff_unknowns(mdl_active);
        rs.idx = rq.row;
        rs.value = '0;
        rs.status = ST_OK;
        fill = mdl_fill[rq.row];
        found = 1'b0;
        pos = 0;
        if (rq.req == REQ_ASSIGN && rq.row < n) begin
            for (int i = 0; i < fill; i++) begin
                if (!found && mdl_col[rq.row][i] == rq.col) begin
                    mdl_val[rq.row][i] = rq.data;
                    found = 1'b1;
                end
            end
            if (!found) begin
                if (fill >= SLOTS) begin
                    rs.status = ST_ROWFULL;
                end else begin
                    mdl_col[rq.row][fill] = rq.col;
                    mdl_val[rq.row][fill] = rq.data;
                    mdl_fill[rq.row] = fill + 1;
                end
            end
        end else if (rq.req == REQ_SETDIAG && rq.row < n) begin
            sum = rq.data < 0 ? -longint'(rq.data) : longint'(rq.data);
            for (int i = 0; i < fill; i++) begin
                if (mdl_col[rq.row][i] == rq.row) begin
                    pos = i;
                    found = 1'b1;
                end else begin
                    sum -= mdl_val[rq.row][i];
                end
            end
            if (found) begin
                mdl_val[rq.row][pos] = clamp32(sum);
            end else if (fill >= SLOTS) begin
                rs.status = ST_ROWFULL;
            end else begin
                mdl_col[rq.row][fill] = rq.row;
                mdl_val[rq.row][fill] = clamp32(sum);
                mdl_fill[rq.row] = fill + 1;
            end
        end else if (rq.req == REQ_LOAD && rq.row < n) begin
            mdl_rhs[rq.row] = rq.data;
        end else if (rq.req == REQ_SOLVE) begin
            div_zero = 1'b0;
            cg_solve(n);
            if (div_zero) rs.status = ST_ZERODIV;
        end else if (rq.req == REQ_READ && rq.row < n) begin
            rs.value = mdl_x[rq.row];
        end
        return rs;
    endfunction

    // Request driver
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                expected_responses.push_back(apply_request('{i_req_type, i_row_index,
                                                             i_column_index, i_data_value}));
            if (!i_valid || !o_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 11) == 0) begin
                    tx_gap = $urandom_range(1, 19) - 1;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    request_t rq;
                    rq = pending_requests.pop_front();
                    i_req_type <= rq.req;
                    i_row_index <= rq.row;
                    i_column_index <= rq.col;
                    i_data_value <= rq.data;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and receiver stalls
    int rx_gap = 0;
    int rx_hold = 0;
    int long_hold_seen = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_responses.size() == 0) begin
                    $error("unexpected response index %0d", o_result_index);
                    fails++;
                end else begin
                    response_t ex;
                    ex = expected_responses.pop_front();
                    if (o_result_index !== ex.idx) begin
                        $error("result_index expected %0d actual %0d", ex.idx, o_result_index);
                        fails++;
                    end
                    if (o_result_value !== ex.value) begin
                        $error("result_value expected %0d actual %0d", ex.value, o_result_value);
                        fails++;
                    end
                    if (o_status !== ex.status) begin
                        $error("status expected %0d actual %0d", ex.status, o_status);
                        fails++;
                    end
                end
            end
            if (long_hold_seen != long_hold_req) begin
                long_hold_seen = long_hold_req;
                rx_hold = LONG_HOLD;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_stall <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                rx_gap = $urandom_range(1, 19) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles without any handshake
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus side bookkeeping: which rhs elements are loaded
    int gen_n;
    bit gen_rhs_set[NMAX];
    int solves_left;

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return Q_MAX;
            1: return Q_MIN;
            2, 3: return $urandom();
            default: return $signed($urandom_range(0, 262144)) - 131072;
        endcase
    endfunction

    function automatic void queue_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] row,
                                          logic [IDX_W-1:0] col, logic signed [DATA_W-1:0] d);
        if (req == REQ_SOLVE) begin
            // load every rhs element still unset before a solve may read it
            for (int i = 0; i < gen_n; i++) begin
                if (!gen_rhs_set[i]) begin
                    pending_requests.push_back('{REQ_LOAD, i[IDX_W-1:0], IDX_W'($urandom()),
                                                rand_value()});
                    gen_rhs_set[i] = 1'b1;
                end
            end
        end
        if (req == REQ_LOAD && row < gen_n) gen_rhs_set[row] = 1'b1;
        pending_requests.push_back('{req, row, col, d});
    endfunction

    function automatic logic [IDX_W-1:0] rand_row();
        if ($urandom_range(0, 9) == 0) return IDX_W'($urandom());
        return IDX_W'($urandom_range(0, gen_n - 1));
    endfunction

    function automatic void queue_random();
        int pick;
        logic [IDX_W-1:0] col;
        pick = $urandom_range(0, 99);
        col = ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(0, gen_n - 1)) : IDX_W'($urandom());
        if (pick < 30) begin
            queue_request(REQ_ASSIGN, rand_row(), col, rand_value());
        end else if (pick < 45) begin
            queue_request(REQ_SETDIAG, rand_row(), col, rand_value());
        end else if (pick < 65) begin
            queue_request(REQ_LOAD, rand_row(), col, rand_value());
        end else if (pick < 70 && solves_left > 0) begin
            solves_left--;
            queue_request(REQ_SOLVE, rand_row(), col, rand_value());
        end else if (pick < 97) begin
            queue_request(REQ_READ, rand_row(), col, rand_value());
        end else begin
            queue_request(REQ_W'($urandom_range(REQ_READ + 1, REQ_TOP)), IDX_W'($urandom()),
                          col, rand_value());
        end
    endfunction

    task automatic write_reg(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] d);
        i_cfg_index <= idx;
        i_cfg_data <= d;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ACTIVE) begin
            mdl_active = d;
            gen_n = eff_unknowns(d);
        end else begin
            mdl_maxit = d;
        end
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || i_valid || expected_responses.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic setup(logic [CFG_W-1:0] act, logic [CFG_W-1:0] it, int solves);
        write_reg(CFG_ACTIVE, act);
        write_reg(CFG_MAXIT, it);
        solves_left = solves;
    endtask

    initial begin
        logic [CFG_W-1:0] act_pick[7] = '{8'd2, 8'd3, 8'd4, 8'd5, 8'd8, 8'd12, 8'd16};
        mdl_active = CFG_N_RST;
        mdl_maxit = CFG_IT_RST;
        gen_n = eff_unknowns(CFG_N_RST);
        mdl_rdot = 0;
        for (int i = 0; i < NMAX; i++) begin
            mdl_fill[i] = 0;
            mdl_x[i] = '0;
            mdl_rhs[i] = '0;
            gen_rhs_set[i] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full row, overwrite, diagonal rules, ranges, zero divisor
        setup(8'd4, 8'd3, 0);
        queue_request(REQ_ASSIGN, 7'd0, 7'd0, Q_MAX);
        queue_request(REQ_ASSIGN, 7'd0, 7'd1, Q_MIN);
        queue_request(REQ_ASSIGN, 7'd0, 7'd2, 32'sd0);
        queue_request(REQ_ASSIGN, 7'd0, 7'd3, -32'sd1);
        queue_request(REQ_ASSIGN, 7'd0, 7'd4, 32'sd65536);
        queue_request(REQ_ASSIGN, 7'd0, 7'd5, 32'sd1);
        queue_request(REQ_ASSIGN, 7'd0, 7'd127, -32'sd65536);
        queue_request(REQ_ASSIGN, 7'd0, 7'd9, 32'sd5);
        queue_request(REQ_ASSIGN, 7'd0, 7'd2, 32'sd32768);
        queue_request(REQ_SETDIAG, 7'd0, 7'd0, Q_MIN);
        queue_request(REQ_SETDIAG, 7'd1, 7'd0, 32'sd196608);
        queue_request(REQ_SETDIAG, 7'd2, 7'd0, -32'sd131072);
        queue_request(REQ_SETDIAG, 7'd3, 7'd0, 32'sd131072);
        queue_request(REQ_ASSIGN, 7'd127, 7'd1, 32'sd7);
        queue_request(REQ_LOAD, 7'd100, 7'd0, 32'sd9);
        queue_request(REQ_READ, 7'd127, 7'd0, 32'sd0);
        queue_request(REQ_TOP, 7'd127, 7'd127, -32'sd1);
        for (int i = 0; i < 4; i++) queue_request(REQ_LOAD, i[IDX_W-1:0], 7'd0, 32'sd0);
        queue_request(REQ_SOLVE, 7'd0, 7'd0, 32'sd0);
        for (int i = 0; i < 4; i++) queue_request(REQ_LOAD, i[IDX_W-1:0], 7'd0, 32'sd65536 * (i + 1));
        queue_request(REQ_SOLVE, 7'd5, 7'd0, 32'sd0);
        queue_request(REQ_READ, 7'd0, 7'd0, 32'sd0);
        queue_request(REQ_READ, 7'd3, 7'd0, 32'sd0);
        drain();

        // Random phases across settings
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) setup(8'd200, 8'd0, 1);
            else if (ph == 7) setup(8'd0, 8'd255, 2);
            else if (ph == 9) setup(8'd128, 8'd1, 1);
            else setup(act_pick[$urandom_range(0, 6)], CFG_W'($urandom_range(0, 6)), 8);
            if (ph == 11) quiet = 1'b1;
            if (ph == 2) long_hold_req++;
            for (int k = 0; k < 105; k++) begin
                // sender pause until all responses are back
                if (ph == 3 && k == 50) drain();
                queue_random();
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
